// ===== src/bslb_pkg.sv =====
// Shared types, codes and helpers of the brush stamp line blitter.
package bslb_pkg;

    localparam int NUM_W   = 18;
    localparam int CRD_W   = 14;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [1:0] ACT_STROKE = 2'd0;
    localparam logic [1:0] ACT_TEXEL  = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [2:0] CFG_RED    = 3'd0;
    localparam logic [2:0] CFG_GREEN  = 3'd1;
    localparam logic [2:0] CFG_BLUE   = 3'd2;
    localparam logic [2:0] CFG_STEPS  = 3'd3;
    localparam logic [2:0] CFG_MASK_W = 3'd4;
    localparam logic [2:0] CFG_MASK_H = 3'd5;
    localparam logic [2:0] CFG_LOADED = 3'd6;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_STAMP,
        OP_TEXEL,
        OP_READ,
        OP_CLEAR
    } t_op;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_RD_ADDR,
        B_RD_DATA,
        B_STEP,
        B_DIV,
        B_SETUP,
        B_CLIP,
        B_ISSUE,
        B_MIX,
        B_WRITE,
        B_FIN
    } t_back_state;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [6:0] steps;
        logic [6:0] mask_w;
        logic [6:0] mask_h;
        logic       loaded;
    } t_cfg;

    typedef struct packed {
        t_op                op;
        logic [10:0]        ox;
        logic [9:0]         oy;
        logic signed [11:0] dx;
        logic signed [10:0] dy;
        logic [6:0]         steps;
        logic [6:0]         mw;
        logic [6:0]         mh;
        logic [11:0]        tidx;
        logic [7:0]         tval;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic boot;
    } t_back_stat;

    function automatic logic [6:0] f_clamp7(input logic [6:0] v, input int hi);
        logic [6:0] r;
        r = v;
        if (v == 7'd0) begin
            r = 7'd1;
        end else if (int'(v) > hi) begin
            r = 7'(hi);
        end
        return r;
    endfunction

    // exact s / 255 for s below 65280
    function automatic logic [7:0] f_div255(input logic [15:0] s);
        logic [16:0] t;
        t = {1'b0, s} + 17'd1 + {9'b0, s[15:8]};
        return t[15:8];
    endfunction

endpackage

// ===== src/bslb_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bslb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/bslb_front.sv =====
// Front end: accepts words, classifies them and tracks the last stroke point.
module bslb_front #(
    parameter int CANVAS_WIDTH  = 1024,
    parameter int CANVAS_HEIGHT = 768,
    parameter int MASK_MAX      = 64,
    parameter int STEPS_MAX     = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_action,
    input  logic [10:0]             i_coord_x,
    input  logic [9:0]              i_coord_y,
    input  logic                    i_new_stroke,
    input  logic [11:0]             i_texel_index,
    input  logic [7:0]              i_texel_value,
    input  bslb_pkg::t_cfg          i_cfg,
    input  bslb_pkg::t_q_stat       i_q,
    input  bslb_pkg::t_back_stat    i_back,
    output logic                    o_push,
    output bslb_pkg::t_cmd          o_cmd
);
    import bslb_pkg::*;

    localparam int MASK_DEPTH = MASK_MAX * MASK_MAX;

    logic [10:0] r_last_x, n_last_x;
    logic [9:0]  r_last_y, n_last_y;
    logic [10:0] w_ox;
    logic [9:0]  w_oy;
    logic        w_acc;

    assign busy  = i_q.full || i_back.boot;
    assign w_acc = start && !busy;
    assign o_push = w_acc;

    assign w_ox = i_new_stroke ? i_coord_x : r_last_x;
    assign w_oy = i_new_stroke ? i_coord_y : r_last_y;

    always_comb begin
        o_cmd       = '0;
        o_cmd.op    = OP_NONE;
        o_cmd.tidx  = i_texel_index;
        o_cmd.tval  = i_texel_value;
        o_cmd.ox    = i_coord_x;
        o_cmd.oy    = i_coord_y;
        n_last_x    = r_last_x;
        n_last_y    = r_last_y;
        unique case (i_action)
            ACT_STROKE: begin
                if (i_cfg.loaded) begin
                    o_cmd.op    = OP_STAMP;
                    o_cmd.ox    = w_ox;
                    o_cmd.oy    = w_oy;
                    o_cmd.dx    = $signed({1'b0, i_coord_x}) - $signed({1'b0, w_ox});
                    o_cmd.dy    = $signed({1'b0, i_coord_y}) - $signed({1'b0, w_oy});
                    o_cmd.mw    = f_clamp7(i_cfg.mask_w, MASK_MAX);
                    o_cmd.mh    = f_clamp7(i_cfg.mask_h, MASK_MAX);
                    o_cmd.steps = f_clamp7(i_cfg.steps, STEPS_MAX);
                    if (i_new_stroke || (i_coord_x == w_ox && i_coord_y == w_oy)) begin
                        o_cmd.steps = 7'd1;
                    end
                    n_last_x = i_coord_x;
                    n_last_y = i_coord_y;
                end
            end
            ACT_TEXEL: begin
                if (32'(i_texel_index) < 32'(MASK_DEPTH)) begin
                    o_cmd.op = OP_TEXEL;
                end
            end
            ACT_READ: begin
                if (32'(i_coord_x) < 32'(CANVAS_WIDTH) &&
                    32'(i_coord_y) < 32'(CANVAS_HEIGHT)) begin
                    o_cmd.op = OP_READ;
                end
            end
            ACT_CLEAR: begin
                o_cmd.op = OP_CLEAR;
            end
            default: begin
                o_cmd.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= '0;
            r_last_y <= '0;
        end else if (w_acc) begin
            r_last_x <= n_last_x;
            r_last_y <= n_last_y;
        end
    end
endmodule

// ===== src/bslb_fifo.sv =====
// Short command queue between the front end and the back end.
module bslb_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bslb_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output bslb_pkg::t_cmd    o_head,
    output bslb_pkg::t_q_stat o_stat
);
    import bslb_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;
    logic            w_push, w_pop;

    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW+1)'(w_push) - (Q_AW+1)'(w_pop);
        end
    end
endmodule

// ===== src/bslb_back.sv =====
// Back end: executes commands on the canvas and mask memories.
module bslb_back #(
    parameter int CANVAS_WIDTH  = 1024,
    parameter int CANVAS_HEIGHT = 768,
    parameter int MASK_MAX      = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bslb_pkg::t_cfg          i_cfg,
    input  bslb_pkg::t_cmd          i_head,
    input  bslb_pkg::t_q_stat       i_q,
    output logic                    o_pop,
    output bslb_pkg::t_back_stat    o_stat,
    output logic                    o_done,
    output logic [7:0]              o_pixel_red,
    output logic [7:0]              o_pixel_green,
    output logic [7:0]              o_pixel_blue,
    output logic                    o_stroke_drawn
);
    import bslb_pkg::*;

    localparam int C_DEPTH    = CANVAS_WIDTH * CANVAS_HEIGHT;
    localparam int CA_W       = $clog2(C_DEPTH);
    localparam int MASK_DEPTH = MASK_MAX * MASK_MAX;
    localparam int MA_W       = $clog2(MASK_DEPTH);
    localparam logic signed [CRD_W-1:0] CW_S = CRD_W'(CANVAS_WIDTH);
    localparam logic signed [CRD_W-1:0] CH_S = CRD_W'(CANVAS_HEIGHT);

    typedef struct packed {
        logic       vld;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       drawn;
    } t_res;

    t_back_state r_state, n_state;
    t_cmd        r_cmd;
    t_res        r_res, w_res;
    logic        r_boot;
    logic [CA_W-1:0] r_clr, r_caddr;
    logic [6:0]  r_k;
    logic [NUM_W-1:0] r_numx, r_numy;
    logic [6:0]  r_remx, r_remy;
    logic [4:0]  r_cnt;
    logic signed [CRD_W-1:0] r_tx, r_ty, r_x0, r_x1, r_y1, r_x, r_y;
    logic        r_skip;
    logic [15:0] r_sr, r_sg, r_sb;

    logic [7:0]  w_shx, w_shy;
    logic        w_gex, w_gey;
    logic [10:0] w_adx;
    logic [9:0]  w_ady;
    logic signed [CRD_W-1:0] w_qx, w_qy, w_cx, w_cy, w_tx, w_ty;
    logic signed [CRD_W-1:0] w_x0, w_y0, w_x1a, w_y1a, w_x1, w_y1;
    logic        w_empty, w_more_x, w_more_y, w_more_k, w_clr_end, w_skip;
    logic [6:0]  w_toy, w_tox;
    logic [13:0] w_t;
    logic        w_t_ok;
    logic [CA_W-1:0] w_caddr;
    logic [7:0]  w_m;
    logic [23:0] w_p;
    logic        w_cwe, w_mwe;
    logic [CA_W-1:0] w_cwaddr;
    logic [23:0] w_cwdata;

    assign w_adx = r_cmd.dx[11] ? 11'(-r_cmd.dx) : r_cmd.dx[10:0];
    assign w_ady = r_cmd.dy[10] ? 10'(-r_cmd.dy) : r_cmd.dy[9:0];

    assign w_shx = {r_remx, r_numx[NUM_W-1]};
    assign w_shy = {r_remy, r_numy[NUM_W-1]};
    assign w_gex = w_shx >= {1'b0, r_cmd.steps};
    assign w_gey = w_shy >= {1'b0, r_cmd.steps};

    assign w_qx = r_cmd.dx[11] ? -CRD_W'(r_numx) : CRD_W'(r_numx);
    assign w_qy = r_cmd.dy[10] ? -CRD_W'(r_numy) : CRD_W'(r_numy);
    assign w_cx = $signed({3'b0, r_cmd.ox}) + w_qx;
    assign w_cy = $signed({4'b0, r_cmd.oy}) + w_qy;
    assign w_tx = w_cx - $signed({8'b0, r_cmd.mw[6:1]});
    assign w_ty = w_cy - $signed({8'b0, r_cmd.mh[6:1]});

    assign w_x0  = r_tx[CRD_W-1] ? '0 : r_tx;
    assign w_y0  = r_ty[CRD_W-1] ? '0 : r_ty;
    assign w_x1a = r_tx + $signed({7'b0, r_cmd.mw});
    assign w_y1a = r_ty + $signed({7'b0, r_cmd.mh});
    assign w_x1  = (w_x1a > CW_S) ? CW_S : w_x1a;
    assign w_y1  = (w_y1a > CH_S) ? CH_S : w_y1a;
    assign w_empty = (w_x0 >= w_x1) || (w_y0 >= w_y1);

    assign w_more_x = (r_x + CRD_W'(1)) < r_x1;
    assign w_more_y = (r_y + CRD_W'(1)) < r_y1;
    assign w_more_k = ({1'b0, r_k} + 8'd1) < {1'b0, r_cmd.steps};
    assign w_clr_end = (r_clr == CA_W'(C_DEPTH - 1));

    assign w_toy  = 7'(r_y - r_ty);
    assign w_tox  = 7'(r_x - r_tx);
    assign w_t    = ({7'b0, w_toy} * {7'b0, r_cmd.mw}) + {7'b0, w_tox};
    assign w_t_ok = 32'(w_t) < 32'(MASK_DEPTH);
    assign w_caddr = CA_W'(32'(r_y[11:0]) * 32'(CANVAS_WIDTH) + 32'(r_x[11:0]));
    assign w_skip = r_skip || (w_m == 8'd0);

    bslb_ram #(.WIDTH(24), .DEPTH(C_DEPTH)) u_canvas (
        .i_clk   (i_clk),
        .i_we    (w_cwe),
        .i_waddr (w_cwaddr),
        .i_wdata (w_cwdata),
        .i_raddr (w_caddr),
        .o_rdata (w_p)
    );

    bslb_ram #(.WIDTH(8), .DEPTH(MASK_DEPTH)) u_mask (
        .i_clk   (i_clk),
        .i_we    (w_mwe),
        .i_waddr (MA_W'(i_head.tidx)),
        .i_wdata (i_head.tval),
        .i_raddr (MA_W'(w_t)),
        .o_rdata (w_m)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR:   if (w_clr_end) n_state = B_IDLE;
            B_IDLE: begin
                if (!i_q.empty) begin
                    unique case (i_head.op)
                        OP_READ:  n_state = B_RD_ADDR;
                        OP_STAMP: n_state = B_STEP;
                        OP_CLEAR: n_state = B_CLEAR;
                        default:  n_state = B_IDLE;
                    endcase
                end
            end
            B_RD_ADDR: n_state = B_RD_DATA;
            B_RD_DATA: n_state = B_IDLE;
            B_STEP:    n_state = B_DIV;
            B_DIV:     if (r_cnt == 5'(NUM_W - 1)) n_state = B_SETUP;
            B_SETUP:   n_state = B_CLIP;
            B_CLIP: begin
                if (!w_empty) n_state = B_ISSUE;
                else if (w_more_k) n_state = B_STEP;
                else n_state = B_FIN;
            end
            B_ISSUE:   n_state = B_MIX;
            B_MIX, B_WRITE: begin
                if (r_state == B_MIX && !w_skip) n_state = B_WRITE;
                else if (w_more_x || w_more_y) n_state = B_ISSUE;
                else if (w_more_k) n_state = B_STEP;
                else n_state = B_FIN;
            end
            B_FIN:     n_state = B_IDLE;
            default:   n_state = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop    = 1'b0;
        w_cwe    = 1'b0;
        w_mwe    = 1'b0;
        w_cwaddr = r_caddr;
        w_cwdata = {f_div255(r_sr), f_div255(r_sg), f_div255(r_sb)};
        w_res    = '0;
        unique case (r_state)
            B_CLEAR: begin
                w_cwe    = 1'b1;
                w_cwaddr = r_clr;
                w_cwdata = '0;
                w_res.vld = w_clr_end && !r_boot;
            end
            B_IDLE: begin
                o_pop = !i_q.empty;
                if (!i_q.empty && (i_head.op == OP_NONE || i_head.op == OP_TEXEL)) begin
                    w_res.vld = 1'b1;
                end
                w_mwe = !i_q.empty && (i_head.op == OP_TEXEL);
            end
            B_RD_DATA: begin
                w_res.vld   = 1'b1;
                w_res.red   = w_p[23:16];
                w_res.green = w_p[15:8];
                w_res.blue  = w_p[7:0];
            end
            B_WRITE: w_cwe = 1'b1;
            B_FIN: begin
                w_res.vld   = 1'b1;
                w_res.drawn = 1'b1;
            end
            default: w_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_boot  <= 1'b1;
            r_clr   <= '0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_res   <= w_res;
            if (r_state == B_CLEAR) begin
                r_clr <= r_clr + 1'b1;
                if (w_clr_end) r_boot <= 1'b0;
            end
            if (r_state == B_IDLE) r_clr <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_cmd <= i_head;
                r_k   <= '0;
                r_x   <= $signed({3'b0, i_head.ox});
                r_y   <= $signed({4'b0, i_head.oy});
            end
            B_STEP: begin
                r_numx <= NUM_W'(w_adx) * NUM_W'(r_k);
                r_numy <= NUM_W'(w_ady) * NUM_W'(r_k);
                r_remx <= '0;
                r_remy <= '0;
                r_cnt  <= '0;
            end
            B_DIV: begin
                r_numx <= {r_numx[NUM_W-2:0], w_gex};
                r_numy <= {r_numy[NUM_W-2:0], w_gey};
                r_remx <= w_gex ? 7'(w_shx - {1'b0, r_cmd.steps}) : w_shx[6:0];
                r_remy <= w_gey ? 7'(w_shy - {1'b0, r_cmd.steps}) : w_shy[6:0];
                r_cnt  <= r_cnt + 5'd1;
            end
            B_SETUP: begin
                r_tx <= w_tx;
                r_ty <= w_ty;
            end
            B_CLIP: begin
                r_x0 <= w_x0;
                r_x1 <= w_x1;
                r_y1 <= w_y1;
                r_x  <= w_x0;
                r_y  <= w_y0;
                if (w_empty) r_k <= r_k + 7'd1;
            end
            B_ISSUE: begin
                r_skip  <= !w_t_ok;
                r_caddr <= w_caddr;
            end
            B_MIX: begin
                r_sr <= ({8'b0, w_p[23:16]} * {8'b0, 8'd255 - w_m})
                      + ({8'b0, i_cfg.red} * {8'b0, w_m});
                r_sg <= ({8'b0, w_p[15:8]} * {8'b0, 8'd255 - w_m})
                      + ({8'b0, i_cfg.green} * {8'b0, w_m});
                r_sb <= ({8'b0, w_p[7:0]} * {8'b0, 8'd255 - w_m})
                      + ({8'b0, i_cfg.blue} * {8'b0, w_m});
            end
            default: begin
            end
        endcase
        // advance to the next texel, row or stamp
        if ((r_state == B_MIX && w_skip) || r_state == B_WRITE) begin
            if (w_more_x) begin
                r_x <= r_x + CRD_W'(1);
            end else if (w_more_y) begin
                r_x <= r_x0;
                r_y <= r_y + CRD_W'(1);
            end else begin
                r_k <= r_k + 7'd1;
            end
        end
    end

    assign o_stat.boot    = r_boot;
    assign o_done         = r_res.vld;
    assign o_pixel_red    = r_res.red;
    assign o_pixel_green  = r_res.green;
    assign o_pixel_blue   = r_res.blue;
    assign o_stroke_drawn = r_res.drawn;

`ifndef SYNTHESIS
    a_no_result_boot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_boot |-> !r_res.vld) else $error("result during boot clear");
    a_boot_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_boot) |-> r_state == B_IDLE) else $error("boot clear did not end idle");
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_DIV |=> (r_state == B_DIV || r_state == B_SETUP))
        else $error("divider left early");
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_WRITE |-> 32'(r_caddr) < 32'(C_DEPTH))
        else $error("canvas write out of range");
`endif
endmodule

// ===== src/brush_stamp_line_blitter_core.sv =====
// Top level of the brush stamp line blitter: config registers, front, queue, back.
//
//  channel  direction  handshake                      payload
//  command  in         start & !busy                  i_action .. i_texel_value
//  result   out        o_done (one cycle, no stall)   o_pixel_*, o_stroke_drawn
//  config   in         i_cfg_valid & o_cfg_ready      i_cfg_index, i_cfg_data
//
//  Clear: one canvas word per cycle. Stroke: for each stamp the back end steps, runs
//  the center divider, sets up and clips, then issues and mixes each mask texel
//  inside the canvas and writes it back if it is nonzero.
//  After reset the canvas is cleared; busy stays high meanwhile. busy also
//  rises when the four-word queue fills.
module brush_stamp_line_blitter_core #(
    parameter int CANVAS_WIDTH  = 1024,
    parameter int CANVAS_HEIGHT = 768,
    parameter int MASK_MAX      = 64,
    parameter int STEPS_MAX     = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [10:0] i_coord_x,
    input  logic [9:0]  i_coord_y,
    input  logic        i_new_stroke,
    input  logic [11:0] i_texel_index,
    input  logic [7:0]  i_texel_value,
    output logic        o_done,
    output logic [7:0]  o_pixel_red,
    output logic [7:0]  o_pixel_green,
    output logic [7:0]  o_pixel_blue,
    output logic        o_stroke_drawn,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import bslb_pkg::*;

    t_cfg       r_cfg;
    t_cmd       w_cmd, w_head;
    t_q_stat    w_q;
    t_back_stat w_back;
    logic       w_push, w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red    <= 8'd255;
            r_cfg.green  <= 8'd255;
            r_cfg.blue   <= 8'd255;
            r_cfg.steps  <= 7'd40;
            r_cfg.mask_w <= 7'd18;
            r_cfg.mask_h <= 7'd18;
            r_cfg.loaded <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RED:    r_cfg.red    <= i_cfg_data;
                CFG_GREEN:  r_cfg.green  <= i_cfg_data;
                CFG_BLUE:   r_cfg.blue   <= i_cfg_data;
                CFG_STEPS:  r_cfg.steps  <= i_cfg_data[6:0];
                CFG_MASK_W: r_cfg.mask_w <= i_cfg_data[6:0];
                CFG_MASK_H: r_cfg.mask_h <= i_cfg_data[6:0];
                CFG_LOADED: r_cfg.loaded <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    bslb_front #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT),
        .MASK_MAX      (MASK_MAX),
        .STEPS_MAX     (STEPS_MAX)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_new_stroke  (i_new_stroke),
        .i_texel_index (i_texel_index),
        .i_texel_value (i_texel_value),
        .i_cfg         (r_cfg),
        .i_q           (w_q),
        .i_back        (w_back),
        .o_push        (w_push),
        .o_cmd         (w_cmd)
    );

    bslb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q)
    );

    bslb_back #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT),
        .MASK_MAX      (MASK_MAX)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (w_head),
        .i_q            (w_q),
        .o_pop          (w_pop),
        .o_stat         (w_back),
        .o_done         (o_done),
        .o_pixel_red    (o_pixel_red),
        .o_pixel_green  (o_pixel_green),
        .o_pixel_blue   (o_pixel_blue),
        .o_stroke_drawn (o_stroke_drawn)
    );
endmodule

// ===== sim/brush_stamp_line_blitter_core_tb.sv =====
// Self-checking testbench for the brush stamp line blitter core with a built-in predictor.
`timescale 1ns / 100ps

module brush_stamp_line_blitter_core_tb;
    import bslb_pkg::*;

    localparam int CW = 1024;
    localparam int CH = 768;
    localparam int MMAX = 64;
    localparam int SMAX = 64;

    typedef enum logic [1:0] {
        W_CMD,
        W_CFG,
        W_HOLD
    } t_word_kind;

    typedef struct {
        t_word_kind  kind;
        logic [1:0]  action;
        logic [10:0] x;
        logic [9:0]  y;
        logic        ns;
        logic [11:0] tidx;
        logic [7:0]  tval;
        logic [2:0]  reg_idx;
        logic [7:0]  reg_data;
        int          gap;
    } t_word;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       drawn;
    } t_pixel_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [10:0] i_coord_x;
    logic [9:0]  i_coord_y;
    logic        i_new_stroke;
    logic [11:0] i_texel_index;
    logic [7:0]  i_texel_value;
    logic        o_done;
    logic [7:0]  o_pixel_red;
    logic [7:0]  o_pixel_green;
    logic [7:0]  o_pixel_blue;
    logic        o_stroke_drawn;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    brush_stamp_line_blitter_core uut (.*);

    t_word         pending_words[$];
    t_pixel_result expected_pixels[$];

    // predictor state
    logic [23:0] canvas_px[int];
    logic [7:0]  mask_tex[MMAX*MMAX];
    logic [7:0]  col_r, col_g, col_b;
    logic [6:0]  reg_steps, reg_mw, reg_mh;
    logic        reg_loaded;
    int          pen_x, pen_y;

    int errors, n_stroke, n_drawn, n_read, n_texel, n_clear, n_cfg;
    int gap_left, quiet;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic int clamp_to(input logic [6:0] v, input int hi);
        if (v == 0) return 1;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    function automatic logic [7:0] blend(input logic [7:0] p, input logic [7:0] c,
                                         input logic [7:0] m);
        int s;
        s = int'(p) * (255 - int'(m)) + int'(c) * int'(m);
        return 8'(s / 255);
    endfunction

    task automatic stamp(input int cx, input int cy, input int mw, input int mh);
        int tx, ty, x0, y0, x1, y1, t, at;
        logic [7:0] m;
        logic [23:0] p;
        tx = cx - mw / 2;
        ty = cy - mh / 2;
        x0 = tx < 0 ? 0 : tx;
        y0 = ty < 0 ? 0 : ty;
        x1 = tx + mw > CW ? CW : tx + mw;
        y1 = ty + mh > CH ? CH : ty + mh;
        for (int y = y0; y < y1; y++) begin
            for (int x = x0; x < x1; x++) begin
                t = (y - ty) * mw + (x - tx);
                m = mask_tex[t];
                if (m != 0) begin
                    at = y * CW + x;
                    p = canvas_px.exists(at) ? canvas_px[at] : 24'd0;
                    canvas_px[at] = {blend(p[23:16], col_r, m), blend(p[15:8], col_g, m),
                                     blend(p[7:0], col_b, m)};
                end
            end
        end
    endtask

    task automatic predict_word(input t_word w);
        t_pixel_result r;
        int mw, mh, steps, dx, dy, ox, oy, at;
        r = '{8'd0, 8'd0, 8'd0, 1'b0};
        case (w.action)
            ACT_STROKE: begin
                n_stroke++;
                if (reg_loaded) begin
                    mw = clamp_to(reg_mw, MMAX);
                    mh = clamp_to(reg_mh, MMAX);
                    steps = clamp_to(reg_steps, SMAX);
                    if (w.ns) begin
                        pen_x = w.x;
                        pen_y = w.y;
                    end
                    ox = pen_x;
                    oy = pen_y;
                    dx = int'(w.x) - ox;
                    dy = int'(w.y) - oy;
                    if (w.ns || (dx == 0 && dy == 0)) steps = 1;
                    for (int k = 0; k < steps; k++) begin
                        stamp(ox + (dx * k) / steps, oy + (dy * k) / steps, mw, mh);
                    end
                    pen_x = w.x;
                    pen_y = w.y;
                    r.drawn = 1'b1;
                    n_drawn++;
                end
            end
            ACT_TEXEL: begin
                n_texel++;
                mask_tex[w.tidx] = w.tval;
            end
            ACT_READ: begin
                n_read++;
                if (w.x < CW && w.y < CH) begin
                    at = int'(w.y) * CW + int'(w.x);
                    if (canvas_px.exists(at)) {r.red, r.green, r.blue} = canvas_px[at];
                end
            end
            default: begin
                n_clear++;
                canvas_px.delete();
            end
        endcase
        expected_pixels.push_back(r);
    endtask

    task automatic apply_reg(input logic [2:0] idx, input logic [7:0] d);
        n_cfg++;
        case (idx)
            CFG_RED:    col_r = d;
            CFG_GREEN:  col_g = d;
            CFG_BLUE:   col_b = d;
            CFG_STEPS:  reg_steps = d[6:0];
            CFG_MASK_W: reg_mw = d[6:0];
            CFG_MASK_H: reg_mh = d[6:0];
            CFG_LOADED: reg_loaded = d[0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
            gap_left <= 0;
            quiet <= 0;
        end else begin
            quiet <= expected_pixels.size() == 0 ? quiet + 1 : 0;
            if (start && !busy) begin
                start <= 1'b0;
            end else if (i_cfg_valid && o_cfg_ready) begin
                i_cfg_valid <= 1'b0;
                apply_reg(i_cfg_index, i_cfg_data);
            end else if (!start && !i_cfg_valid) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_words.size() > 0) begin
                    if (pending_words[0].kind == W_CMD) begin
                        start <= 1'b1;
                        i_action <= pending_words[0].action;
                        i_coord_x <= pending_words[0].x;
                        i_coord_y <= pending_words[0].y;
                        i_new_stroke <= pending_words[0].ns;
                        i_texel_index <= pending_words[0].tidx;
                        i_texel_value <= pending_words[0].tval;
                        gap_left <= pending_words[0].gap;
                        void'(pending_words.pop_front());
                    end else if (expected_pixels.size() == 0 && quiet > 8) begin
                        if (pending_words[0].kind == W_CFG) begin
                            i_cfg_valid <= 1'b1;
                            i_cfg_index <= pending_words[0].reg_idx;
                            i_cfg_data <= pending_words[0].reg_data;
                        end
                        void'(pending_words.pop_front());
                    end
                end
            end
        end
    end

    // predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            predict_word('{W_CMD, i_action, i_coord_x, i_coord_y, i_new_stroke,
                           i_texel_index, i_texel_value, 3'd0, 8'd0, 0});
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pixel_result e;
        if (i_rst_n && o_done) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                e = expected_pixels.pop_front();
                if (o_pixel_red !== e.red) report_mismatch("red", o_pixel_red, e.red);
                if (o_pixel_green !== e.green)
                    report_mismatch("green", o_pixel_green, e.green);
                if (o_pixel_blue !== e.blue) report_mismatch("blue", o_pixel_blue, e.blue);
                if (o_stroke_drawn !== e.drawn)
                    report_mismatch("stroke_drawn", o_stroke_drawn, e.drawn);
            end
        end
    end

    task automatic add_cmd(input logic [1:0] a, input int x, input int y, input bit ns,
                           input int tidx, input int tval, input int gap);
        pending_words.push_back('{W_CMD, a, 11'(x), 10'(y), ns, 12'(tidx), 8'(tval),
                                  3'd0, 8'd0, gap});
    endtask

    task automatic add_reg(input logic [2:0] idx, input int d);
        pending_words.push_back('{W_CFG, ACT_STROKE, 11'd0, 10'd0, 1'b0, 12'd0, 8'd0,
                                  idx, 8'(d), 0});
    endtask

    task automatic add_hold();
        pending_words.push_back('{W_HOLD, ACT_STROKE, 11'd0, 10'd0, 1'b0, 12'd0, 8'd0,
                                  3'd0, 8'd0, 0});
    endtask

    task automatic add_mask_shape();
        int sel, w, h;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            w = 0;
            h = 127;
        end else if (sel == 1) begin
            w = 127;
            h = 0;
        end else if (sel == 2) begin
            w = 64;
            h = 1;
        end else begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 64 / w);
        end
        add_reg(CFG_MASK_W, w);
        add_reg(CFG_MASK_H, h);
    endtask

    function automatic int near(input int c, input int span, input int hi);
        int v;
        v = c + $urandom_range(0, 2 * span) - span;
        return v < 0 ? 0 : (v > hi ? hi : v);
    endfunction

    initial begin
        int gap, bx, by, a, x, y, sel;
        bit dense;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_valid = 1'b0;
        i_action = ACT_STROKE;
        i_coord_x = '0;
        i_coord_y = '0;
        i_new_stroke = 1'b0;
        i_texel_index = '0;
        i_texel_value = '0;
        i_cfg_index = CFG_RED;
        i_cfg_data = '0;
        errors = 0;
        n_stroke = 0;
        n_drawn = 0;
        n_read = 0;
        n_texel = 0;
        n_clear = 0;
        n_cfg = 0;
        col_r = 8'd255;
        col_g = 8'd255;
        col_b = 8'd255;
        reg_steps = 7'd40;
        reg_mw = 7'd18;
        reg_mh = 7'd18;
        reg_loaded = 1'b0;
        pen_x = 0;
        pen_y = 0;
        foreach (mask_tex[i]) mask_tex[i] = 8'd0;

        // mask load: texels 0..63 cover every shape used below
        for (int i = 0; i < 64; i++) begin
            sel = $urandom_range(0, 5);
            add_cmd(ACT_TEXEL, $urandom_range(0, 2047), $urandom_range(0, 1023), 1'($urandom),
                    i, sel == 0 ? 0 : (sel == 1 ? 255 : $urandom_range(0, 255)),
                    $urandom_range(0, 2));
        end

        // directed
        add_cmd(ACT_STROKE, 10, 10, 1'b1, 4095, 255, 0);
        add_cmd(ACT_TEXEL, 0, 0, 1'b0, 4095, 0, 0);
        add_cmd(ACT_READ, 0, 0, 1'b0, 0, 0, 0);
        add_cmd(ACT_READ, 2047, 1023, 1'b1, 4095, 255, 0);
        add_reg(CFG_RED, 255);
        add_reg(CFG_GREEN, 0);
        add_reg(CFG_BLUE, 128);
        add_reg(CFG_STEPS, 0);
        add_reg(CFG_MASK_W, 8);
        add_reg(CFG_MASK_H, 8);
        add_reg(CFG_LOADED, 1);
        add_cmd(ACT_STROKE, 0, 0, 1'b1, 0, 0, 0);
        add_cmd(ACT_STROKE, 0, 0, 1'b0, 0, 0, 0);
        add_cmd(ACT_READ, 0, 0, 1'b0, 0, 0, 0);
        add_cmd(ACT_READ, 3, 3, 1'b0, 0, 0, 0);
        add_cmd(ACT_STROKE, 1023, 767, 1'b1, 0, 0, 0);
        add_cmd(ACT_READ, 1023, 767, 1'b0, 0, 0, 0);
        add_cmd(ACT_READ, 1024, 768, 1'b0, 0, 0, 0);
        add_cmd(ACT_STROKE, 2047, 1023, 1'b1, 0, 0, 0);
        add_reg(CFG_STEPS, 127);
        add_reg(CFG_MASK_W, 0);
        add_reg(CFG_MASK_H, 127);
        add_cmd(ACT_STROKE, 20, 30, 1'b1, 0, 0, 0);
        add_cmd(ACT_STROKE, 100, 2, 1'b0, 0, 0, 0);
        add_cmd(ACT_READ, 60, 16, 1'b0, 0, 0, 0);
        add_cmd(ACT_READ, 60, 10, 1'b0, 0, 0, 0);
        add_cmd(ACT_CLEAR, 0, 0, 1'b0, 0, 0, 0);
        add_cmd(ACT_READ, 60, 10, 1'b0, 0, 0, 0);
        add_reg(CFG_STEPS, 1);
        add_reg(CFG_MASK_W, 127);
        add_reg(CFG_MASK_H, 0);
        add_cmd(ACT_STROKE, 5, 5, 1'b1, 0, 0, 0);
        add_cmd(ACT_STROKE, 40, 5, 1'b0, 0, 0, 0);
        add_cmd(ACT_READ, 5, 5, 1'b0, 0, 0, 0);
        add_cmd(ACT_READ, 37, 5, 1'b0, 0, 0, 0);

        // random phases
        for (int ph = 0; ph < 10; ph++) begin
            add_reg(CFG_RED, $urandom_range(0, 255));
            add_reg(CFG_GREEN, $urandom_range(0, 255));
            add_reg(CFG_BLUE, $urandom_range(0, 255));
            sel = $urandom_range(0, 4);
            add_reg(CFG_STEPS, sel == 0 ? 1 : (sel == 1 ? 64 : $urandom_range(1, 24)));
            add_mask_shape();
            add_reg(CFG_LOADED, ph == 3 ? 0 : 1);
            dense = $urandom_range(0, 2) == 0;
            bx = $urandom_range(0, 3) == 0 ? 1016 : $urandom_range(0, 200);
            by = $urandom_range(0, 3) == 0 ? 762 : $urandom_range(0, 200);
            x = bx;
            y = by;
            for (int i = 0; i < 2; i++) begin
                gap = dense ? 0 : $urandom_range(0, 8);
                a = $urandom_range(0, 99);
                if (a < 45) begin
                    if ($urandom_range(0, 9) == 0) begin
                        x = $urandom_range(0, 2047);
                        y = $urandom_range(0, 1023);
                    end else begin
                        x = near(bx, 12, 2047);
                        y = near(by, 12, 1023);
                    end
                    add_cmd(ACT_STROKE, x, y, $urandom_range(0, 3) == 0,
                            $urandom_range(0, 4095), $urandom_range(0, 255), gap);
                end else if (a < 85) begin
                    if ($urandom_range(0, 9) == 0)
                        add_cmd(ACT_READ, $urandom_range(0, 2047), $urandom_range(0, 1023),
                                1'($urandom), $urandom_range(0, 4095), $urandom_range(0, 255),
                                gap);
                    else
                        add_cmd(ACT_READ, near(x, 4, 2047), near(y, 4, 1023), 1'($urandom),
                                $urandom_range(0, 4095), $urandom_range(0, 255), gap);
                end else begin
                    add_cmd(ACT_TEXEL, $urandom_range(0, 2047), $urandom_range(0, 1023),
                            1'($urandom),
                            $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                                      : $urandom_range(0, 63),
                            $urandom_range(0, 255), gap);
                end
            end
            if (ph == 5) add_hold();
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_words.size() > 0 || start || i_cfg_valid || expected_pixels.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d strokes (%0d drawn), %0d reads, %0d texel writes, %0d clears,",
                 n_stroke, n_drawn, n_read, n_texel, n_clear);
        $display("and %0d register writes; %0d mismatches", n_cfg, errors);
        if (errors == 0) begin
            $display("** brush_stamp_line_blitter_core: PASSED **");
        end else begin
            $display("** brush_stamp_line_blitter_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #300000000;
        $display("timeout with %0d words still expected", expected_pixels.size());
        $display("** brush_stamp_line_blitter_core: FAILED **");
        $finish;
    end

endmodule
